@@ src/acnt_pkg.sv @@
package acnt_pkg;

  localparam int NAME_W = 64;
  localparam int ADDR_W = 8;
  localparam int PORT_W = 2;

  localparam logic [ADDR_W-1:0] NULL_ADDR = 8'd254;
  // PDU1 address-claim PGN: PF 0xEE, DP/EDP zero.
  localparam logic [9:0] CLAIM_PGN_HI = 10'h0EE;
  localparam logic [3:0] CLAIM_LENGTH = 4'd8;

  typedef enum logic [1:0] {
    STATUS_IGNORED = 2'd0,
    STATUS_UPDATED = 2'd1,
    STATUS_ADDED   = 2'd2,
    STATUS_FULL    = 2'd3
  } claim_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic [28:0]       can_identifier;
    logic [3:0]        frame_length;
    logic [NAME_W-1:0] claimed_name;
    logic [PORT_W-1:0] port_index;
  } claim_in_t;

  typedef struct packed {
    claim_status_t claim_status;
    logic [4:0]    entry_index;
    logic [5:0]    displaced_count;
  } claim_out_t;

  typedef struct packed {
    logic [NAME_W-1:0] name;
    logic [ADDR_W-1:0] address;
    logic [PORT_W-1:0] port;
  } node_entry_t;

  typedef struct packed {
    logic name_hit;
    logic addr_hit;
  } match_t;

  // With PF below 0xF0 the PGN is bits 25..16 shifted up by 8. With PF at or
  // above 0xF0 the PGN can never equal the claim PGN, so only PDU1 is checked.
  function automatic logic is_claim_id(input logic [28:0] id);
    return (id[25:16] == CLAIM_PGN_HI);
  endfunction

endpackage

@@ src/acnt_table.sv @@
module acnt_table #(
  parameter int TABLE_DEPTH = 32,
  parameter int IDX_W = 5
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  acnt_pkg::node_entry_t wr_data,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  output acnt_pkg::node_entry_t rd_data
);
  import acnt_pkg::*;

  node_entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/acnt_match.sv @@
module acnt_match (
  input  acnt_pkg::node_entry_t entry,
  input  logic [63:0]           name,
  input  logic [7:0]            source_addr,
  output acnt_pkg::match_t      hit
);
  import acnt_pkg::*;

  always_comb begin
    hit.name_hit = (entry.name == name);
    hit.addr_hit = (entry.address == source_addr);
  end

endmodule

@@ src/address_claim_name_table_core.sv @@
// Tracks J1939 address claims in a table of known nodes. Each request
// transaction carries one received frame; only address-claim frames of length
// 8 on a port below PORT_COUNT are acted on, all others go straight to the
// result stage and return "ignored". A claim sweeps the valid entries through
// the single read port of the node table, one entry per cycle, then writes the
// entry it adds or updates, if any, before its result is loaded. In either case
// the next request is taken only after the result has entered the output register.
// Entries below node_count are valid; no clearing pass is needed after reset. One
// result is held in an output register until the consumer takes it; while it
// waits, a finished second result holds the block and stalls the request side.
module address_claim_name_table_core #(
  parameter int TABLE_DEPTH = 32,
  parameter int PORT_COUNT = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  acnt_pkg::claim_in_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output acnt_pkg::claim_out_t rsp
);
  import acnt_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  seq_state_t state, state_next;

  claim_in_t        req_q;
  logic [CNT_W-1:0] node_count;
  logic [CNT_W-1:0] rd_idx;
  logic             cmp_pending;
  logic [IDX_W-1:0] cmp_idx;
  logic             found;
  logic [IDX_W-1:0] found_slot;
  logic [PORT_W-1:0] found_port;
  logic [CNT_W-1:0] displaced;
  claim_status_t    res_status;
  logic [IDX_W-1:0] res_slot;

  logic        mem_rd_en;
  logic        mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  node_entry_t mem_wr_data;
  node_entry_t mem_rd_data;
  match_t      hit;

  logic accept;
  logic frame_valid;
  logic rsp_load;
  logic scan_done;
  logic table_full;

  assign accept = req_valid && req_ready;
  assign frame_valid = is_claim_id(req.can_identifier) &&
                       (req.frame_length == CLAIM_LENGTH) &&
                       ({30'd0, req.port_index} < 32'(PORT_COUNT));
  assign scan_done = (rd_idx == node_count) && !cmp_pending;
  assign table_full = (node_count == CNT_W'(TABLE_DEPTH));
  assign rsp_load = (state == ST_DONE) && (!rsp_valid || rsp_ready);

  acnt_table #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .IDX_W(IDX_W)
  ) u_table (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (mem_rd_en),
    .rd_addr(rd_idx[IDX_W-1:0]),
    .rd_data(mem_rd_data)
  );

  acnt_match u_match (
    .entry      (mem_rd_data),
    .name       (req_q.claimed_name),
    .source_addr(req_q.can_identifier[7:0]),
    .hit        (hit)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = frame_valid ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: state_next = ST_DONE;
      ST_DONE: begin
        if (rsp_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready   = (state == ST_IDLE);
    mem_rd_en   = 1'b0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = cmp_idx;
    mem_wr_data = mem_rd_data;
    unique case (state)
      ST_SCAN: begin
        mem_rd_en = (rd_idx < node_count);
        // A non-matching entry that holds the claimed address is pushed to null.
        if (cmp_pending && !hit.name_hit && hit.addr_hit) begin
          mem_wr_en           = 1'b1;
          mem_wr_data.address = NULL_ADDR;
        end
      end
      ST_FINISH: begin
        mem_wr_data.name    = req_q.claimed_name;
        mem_wr_data.address = req_q.can_identifier[7:0];
        if (found) begin
          mem_wr_en        = 1'b1;
          mem_wr_addr      = found_slot;
          mem_wr_data.port = found_port;
        end else if (!table_full) begin
          mem_wr_en        = 1'b1;
          mem_wr_addr      = node_count[IDX_W-1:0];
          mem_wr_data.port = req_q.port_index;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      node_count  <= '0;
      cmp_pending <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      state <= state_next;

      if (accept) begin
        req_q      <= req;
        rd_idx     <= '0;
        found      <= 1'b0;
        displaced  <= '0;
        res_status <= STATUS_IGNORED;
        res_slot   <= '0;
      end

      if (state == ST_SCAN) begin
        cmp_pending <= mem_rd_en;
        cmp_idx     <= rd_idx[IDX_W-1:0];
        if (mem_rd_en) begin
          rd_idx <= rd_idx + 1'b1;
        end
        if (cmp_pending) begin
          if (hit.name_hit) begin
            found      <= 1'b1;
            found_slot <= cmp_idx;
            found_port <= mem_rd_data.port;
          end else if (hit.addr_hit) begin
            displaced <= displaced + 1'b1;
          end
        end
      end

      if (state == ST_FINISH) begin
        if (found) begin
          res_status <= STATUS_UPDATED;
          res_slot   <= found_slot;
        end else if (!table_full) begin
          res_status <= STATUS_ADDED;
          res_slot   <= node_count[IDX_W-1:0];
          node_count <= node_count + 1'b1;
        end else begin
          res_status <= STATUS_FULL;
          res_slot   <= '0;
        end
      end

      if (rsp_load) begin
        rsp_valid           <= 1'b1;
        rsp.claim_status    <= res_status;
        rsp.entry_index     <= 5'(res_slot);
        rsp.displaced_count <= 6'(displaced);
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

@@ src/acnt_checker.sv @@
module acnt_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_ready,
  input acnt_pkg::claim_in_t  req,
  input logic                 rsp_valid,
  input logic                 rsp_ready,
  input acnt_pkg::claim_out_t rsp
);
  import acnt_pkg::*;

  // A stalled result must hold.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed or dropped while stalled");

  // Frames are handled one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted on consecutive cycles");

  a_ignored_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.claim_status == STATUS_IGNORED |->
      rsp.entry_index == 5'd0 && rsp.displaced_count == 6'd0)
    else $error("ignored frame reports slot or displacement");

  a_full_slot: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.claim_status == STATUS_FULL |-> rsp.entry_index == 5'd0)
    else $error("table-full result reports a slot");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind address_claim_name_table_core acnt_checker u_acnt_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_ready(req_ready),
  .req      (req),
  .rsp_valid(rsp_valid),
  .rsp_ready(rsp_ready),
  .rsp      (rsp)
);

@@ bench/address_claim_name_table_core_test.sv @@
module address_claim_name_table_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import acnt_pkg::*;

  localparam int TABLE_DEPTH = 32;
  localparam int PORT_COUNT = 4;
  localparam logic [17:0] CLAIM_PGN = 18'h0EE00;
  localparam int NAME_POOL_SIZE = 48;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  claim_in_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  claim_out_t rsp;

  // Shadow copy of the node table.
  logic [NAME_W-1:0] tbl_name [TABLE_DEPTH];
  logic [ADDR_W-1:0] tbl_addr [TABLE_DEPTH];
  logic [PORT_W-1:0] tbl_port [TABLE_DEPTH];
  bit tbl_valid [TABLE_DEPTH];
  int tbl_count = 0;

  claim_out_t pending_results[$];
  claim_out_t next_result;
  logic [NAME_W-1:0] name_pool [NAME_POOL_SIZE];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int stall_cycles = 0;
  int holdoff_req = 0;
  int holdoff_seen = 0;
  int holdoff_left = 0;

  address_claim_name_table_core #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .PORT_COUNT(PORT_COUNT)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic claim_out_t compute_claim_result(input claim_in_t f);
    claim_out_t res;
    logic [7:0] pf;
    logic [7:0] sa;
    logic [17:0] pgn;
    int hit_slot;
    int displaced;
    bit found;
    res.claim_status = STATUS_IGNORED;
    res.entry_index = '0;
    res.displaced_count = '0;
    pf = f.can_identifier[23:16];
    sa = f.can_identifier[7:0];
    if (pf < 8'hF0) begin
      pgn = {f.can_identifier[25:16], 8'h00};
    end else begin
      pgn = f.can_identifier[25:8];
    end
    if (pgn != CLAIM_PGN || f.frame_length != CLAIM_LENGTH || f.port_index >= PORT_COUNT) begin
      return res;
    end
    found = 1'b0;
    hit_slot = 0;
    displaced = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!tbl_valid[i]) continue;
      if (tbl_name[i] == f.claimed_name) begin
        found = 1'b1;
        hit_slot = i;
      end else if (tbl_addr[i] == sa) begin
        tbl_addr[i] = NULL_ADDR;
        displaced++;
      end
    end
    if (found) begin
      // A known node keeps the port it was first seen on.
      tbl_addr[hit_slot] = sa;
      res.claim_status = STATUS_UPDATED;
    end else if (tbl_count < TABLE_DEPTH) begin
      hit_slot = tbl_count;
      tbl_name[hit_slot] = f.claimed_name;
      tbl_addr[hit_slot] = sa;
      tbl_port[hit_slot] = f.port_index;
      tbl_valid[hit_slot] = 1'b1;
      tbl_count++;
      res.claim_status = STATUS_ADDED;
    end else begin
      hit_slot = 0;
      res.claim_status = STATUS_FULL;
    end
    res.entry_index = 5'(hit_slot);
    res.displaced_count = 6'(displaced);
    return res;
  endfunction

  function automatic claim_in_t claim_frame(input logic [2:0] prio, input logic [7:0] ps,
                                            input logic [7:0] sa, input logic [63:0] name,
                                            input logic [1:0] port);
    claim_in_t f;
    f.can_identifier = {prio, CLAIM_PGN_HI, ps, sa};
    f.frame_length = CLAIM_LENGTH;
    f.claimed_name = name;
    f.port_index = port;
    return f;
  endfunction

  function automatic claim_in_t random_claim();
    int r;
    logic [7:0] sa;
    logic [63:0] name;
    r = $urandom_range(99);
    // Crowd the claims onto a few addresses so displacement happens often.
    if (r < 50) sa = 8'($urandom_range(7));
    else if (r < 65) sa = NULL_ADDR;
    else if (r < 75) sa = 8'hFF;
    else sa = 8'($urandom);
    if ($urandom_range(99) < 90) name = name_pool[$urandom_range(NAME_POOL_SIZE - 1)];
    else name = {$urandom, $urandom};
    return claim_frame(3'($urandom), 8'($urandom), sa, name, 2'($urandom));
  endfunction

  function automatic claim_in_t noise_frame();
    claim_in_t f;
    f.claimed_name = {$urandom, $urandom};
    f.port_index = 2'($urandom);
    f.frame_length = 4'($urandom_range(15));
    case ($urandom_range(3))
      0: f.can_identifier = 29'($urandom);
      1: begin
        f.can_identifier = {3'($urandom), CLAIM_PGN_HI, 8'($urandom), 8'($urandom)};
        if (f.frame_length == CLAIM_LENGTH) f.frame_length = 4'($urandom_range(7));
      end
      2: begin
        // Data page bits set: a different PGN.
        f.can_identifier = {3'($urandom), 2'($urandom_range(3, 1)), 8'hEE, 8'($urandom),
                            8'($urandom)};
        f.frame_length = CLAIM_LENGTH;
      end
      default: begin
        f.can_identifier = {3'($urandom), 2'($urandom), 8'($urandom_range(255, 240)), 8'hEE,
                            8'($urandom)};
        f.frame_length = CLAIM_LENGTH;
      end
    endcase
    return f;
  endfunction

  task automatic send_frame(input claim_in_t f);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= f;
    do @(posedge clk); while (!req_ready);
    pending_results = {pending_results, compute_claim_result(f)};
  endtask

  task automatic wait_for_drain();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_frames();
    logic [63:0] name_a;
    logic [63:0] name_b;
    logic [63:0] name_c;
    logic [63:0] name_d;
    name_a = 64'h0123_4567_89AB_CDEF;
    name_b = 64'h0123_4567_89AB_CDEE;
    name_c = 64'h8000_0000_0000_0000;
    name_d = 64'hA5A5_5A5A_C3C3_3C3C;
    send_frame('{can_identifier: 29'd0, frame_length: 4'd8, claimed_name: 64'd0,
                 port_index: 2'd0});
    send_frame('{can_identifier: 29'h1FFF_FFFF, frame_length: 4'd15, claimed_name: '1,
                 port_index: 2'd3});
    send_frame('{can_identifier: {3'd6, 2'b01, 8'hEE, 8'hFF, 8'h10}, frame_length: 4'd8,
                 claimed_name: name_a, port_index: 2'd0});
    send_frame('{can_identifier: {3'd6, 2'b00, 8'hFE, 8'hEE, 8'h10}, frame_length: 4'd8,
                 claimed_name: name_a, port_index: 2'd0});
    send_frame('{can_identifier: {3'd6, 2'b00, 8'hEF, 8'h00, 8'h10}, frame_length: 4'd8,
                 claimed_name: name_a, port_index: 2'd0});
    for (int len = 0; len < 16; len += 7) begin
      // Lengths 0, 7 and 14 around the one that counts.
      send_frame('{can_identifier: {3'd6, CLAIM_PGN_HI, 8'hFF, 8'h10},
                   frame_length: 4'(len), claimed_name: name_a, port_index: 2'd0});
    end
    send_frame(claim_frame(3'd6, 8'hFF, 8'h10, name_a, 2'd0));
    send_frame(claim_frame(3'd6, 8'hFF, 8'h10, name_b, 2'd1));
    send_frame(claim_frame(3'd6, 8'hFF, 8'h20, name_a, 2'd2));
    // Claims of the null address count entries already parked there.
    send_frame(claim_frame(3'd6, 8'hFF, NULL_ADDR, name_c, 2'd3));
    send_frame(claim_frame(3'd6, 8'hFF, NULL_ADDR, name_d, 2'd2));
    send_frame(claim_frame(3'd7, 8'hFF, 8'h00, 64'd0, 2'd1));
    send_frame(claim_frame(3'd0, 8'h00, 8'hFF, '1, 2'd3));
    send_frame(claim_frame(3'd3, 8'h5A, 8'hFF, name_a, 2'd1));
    send_frame(claim_frame(3'd3, 8'h5A, 8'hFF, name_a, 2'd1));
    send_frame(claim_frame(3'd7, 8'hA5, 8'h00, name_b, 2'd0));
    wait_for_drain();
  endtask

  task automatic test_random_claims(input int claim_target);
    int sent;
    sent = 0;
    while (sent < claim_target) begin
      if ($urandom_range(99) < 75) begin
        send_frame(random_claim());
        sent++;
      end else begin
        send_frame(noise_frame());
      end
    end
  endtask

  task automatic test_receiver_holdoff();
    int saved_pct;
    saved_pct = send_idle_pct;
    send_idle_pct = 0;
    holdoff_req <= holdoff_req + 1;
    for (int i = 0; i < 12; i++) send_frame(random_claim());
    send_idle_pct = saved_pct;
  endtask

  task automatic test_sender_pause();
    wait_for_drain();
    for (int i = 0; i < 10; i++) send_frame(random_claim());
  endtask

  // Response side: random back-pressure, plus a long hold-off on request.
  always @(posedge clk) begin
    if (holdoff_seen != holdoff_req) begin
      holdoff_seen <= holdoff_req;
      holdoff_left <= HOLDOFF_CYCLES;
      rsp_ready <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: status %0d slot %0d displaced %0d",
                   rsp.claim_status, rsp.entry_index, rsp.displaced_count);
        end
      end else begin
        next_result = pending_results[0];
        pending_results.delete(0);
        if (rsp.claim_status !== next_result.claim_status ||
            rsp.entry_index !== next_result.entry_index ||
            rsp.displaced_count !== next_result.displaced_count) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch: expected status %0d slot %0d displaced %0d, got %0d %0d %0d",
                     next_result.claim_status, next_result.entry_index,
                     next_result.displaced_count, rsp.claim_status, rsp.entry_index,
                     rsp.displaced_count);
          end
        end
      end
    end
  end

  // Any transaction on either side resets the stall count.
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tbl_name[i] = '0;
      tbl_addr[i] = '0;
      tbl_port[i] = '0;
      tbl_valid[i] = 1'b0;
    end
    // Odd pool entries past the first differ from their neighbor in a single bit.
    name_pool[0] = '0;
    name_pool[1] = '1;
    for (int i = 2; i < NAME_POOL_SIZE; i++) begin
      if (i % 2 == 1) name_pool[i] = name_pool[i - 1] ^ (64'd1 << $urandom_range(63));
      else name_pool[i] = {$urandom, $urandom};
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_directed_frames();
    send_idle_pct = 7;
    recv_idle_pct = 57;
    test_random_claims(400);
    test_receiver_holdoff();
    test_sender_pause();
    send_idle_pct = 57;
    recv_idle_pct = 7;
    test_random_claims(400);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_claims(400);

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
